// ===== src/acss_pkg.sv =====
// Shared types, codes and helpers for the ADC channel scan sequencer.
// Depends on nothing; used by acss_step and the top level.
package acss_pkg;

	localparam int SCAN_MAX     = 8;
	localparam int LIST_ENTRIES = 8;
	localparam int CHAN_W       = 5;
	localparam int LIST_W       = LIST_ENTRIES * CHAN_W;
	localparam int SAMPLE_W     = 10;

	typedef enum logic [1:0] {
		REQ_SINGLE = 2'd0,
		REQ_SCAN   = 2'd1,
		REQ_DONE   = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_BUSY    = 2'd2,
		ST_STRAY   = 2'd3
	} status_t;

	localparam logic [1:0] CFG_EIGHT_BIT = 2'd0;
	localparam logic [1:0] CFG_SCAN_LEN  = 2'd1;
	localparam logic [1:0] CFG_SCAN_LIST = 2'd2;

	typedef struct packed {
		logic              eight_bit;
		logic [3:0]        scan_len;
		logic [LIST_W-1:0] scan_list;
	} cfg_t;

	typedef struct packed {
		logic       busy;
		logic       scan_mode;
		logic [3:0] pos;
		logic [3:0] len;
	} seq_state_t;

	typedef struct packed {
		status_t             status;
		logic                start;
		logic [CHAN_W-1:0]   mux;
		logic                valid;
		logic [2:0]          idx;
		logic [SAMPLE_W-1:0] value;
		logic                done;
	} result_t;

	// Channel number stored at a scan list position; positions past the list read as 0.
	function automatic logic [CHAN_W-1:0] list_entry(logic [LIST_W-1:0] list,
		logic [3:0] pos);
		logic [5:0] base;
		base = {3'b000, pos[2:0]} * 6'd5;
		if (pos >= 4'(LIST_ENTRIES))
			return '0;
		return list[base +: CHAN_W];
	endfunction

endpackage

// ===== src/acss_step.sv =====
// Decision logic for one request or done event: result and next sequencer state.
// Depends on acss_pkg.
module acss_step
	import acss_pkg::*;
(
	input  logic [1:0]          req_type,
	input  logic [5:0]          channel,
	input  logic [SAMPLE_W-1:0] sample,
	input  cfg_t                cfg,
	input  seq_state_t          state,
	output seq_state_t          state_next,
	output result_t             result
);

	logic [3:0] len_clamped;
	logic [3:0] pos_inc;

	assign len_clamped = (cfg.scan_len > 4'(SCAN_MAX)) ? 4'(SCAN_MAX) : cfg.scan_len;
	assign pos_inc     = state.pos + 4'd1;

	always_comb begin
		state_next = state;
		result     = '0;
		result.status = ST_OK;
		case (req_type)
			REQ_SINGLE: begin
				if (channel > 6'd31) begin
					result.status = ST_INVALID;
				end else if (state.busy) begin
					result.status = ST_BUSY;
				end else begin
					state_next.busy      = 1'b1;
					state_next.scan_mode = 1'b0;
					result.start         = 1'b1;
					result.mux           = channel[CHAN_W-1:0];
				end
			end
			REQ_SCAN: begin
				if (len_clamped == 4'd0) begin
					result.status = ST_INVALID;
				end else if (state.busy) begin
					result.status = ST_BUSY;
				end else begin
					state_next.busy      = 1'b1;
					state_next.scan_mode = 1'b1;
					state_next.pos       = 4'd0;
					state_next.len       = len_clamped;
					result.start         = 1'b1;
					result.mux           = list_entry(cfg.scan_list, 4'd0);
				end
			end
			REQ_DONE: begin
				if (!state.busy) begin
					result.status = ST_STRAY;
				end else begin
					result.valid = 1'b1;
					result.value = cfg.eight_bit ? {2'b00, sample[SAMPLE_W-1:2]} : sample;
					if (!state.scan_mode) begin
						state_next.busy = 1'b0;
						result.done     = 1'b1;
					end else begin
						result.idx     = state.pos[2:0];
						state_next.pos = pos_inc;
						if (pos_inc >= state.len) begin
							state_next.busy = 1'b0;
							result.done     = 1'b1;
						end else begin
							result.start = 1'b1;
							result.mux   = list_entry(cfg.scan_list, pos_inc);
						end
					end
				end
			end
			default: begin
				result.status = ST_INVALID;
			end
		endcase
	end

endmodule

// ===== src/adc_channel_scan_sequencer_unit.sv =====
// Top level of the ADC channel scan sequencer: input register, decision logic,
// result register and configuration registers. Depends on acss_pkg and acss_step.
//
//  Channel  Direction  Signals                          Contents
//  s_*      in         s_tvalid s_tready s_tdata s_tuser  request or done event
//  m_*      out        m_tvalid m_tready m_tdata m_tuser  one result per item
//  cfg_*    in         cfg_we cfg_index cfg_wdata       register writes
//
// Every item passes through two registers: the input register (_s1), then the
// result register (_s2), where the sequencer state is updated in the same cycle.
// One item is taken per cycle while the result stream is not stalled; an item moves
// from the input register into the result register, which drives m_tvalid.
// A stalled result holds the result register, and the input register
// fills behind it, so s_tready drops only once both are full.
// The asynchronous reset clears the valid flags and the sequencer state, and sets the
// configuration registers to eight-bit mode, scan length 1 and an all-zero scan list.
module adc_channel_scan_sequencer_unit
	import acss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [5:0] channel, [15:6] sample
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [0] start_conversion, [5:1] mux_channel,
	                               // [6] result_valid, [9:7] result_index,
	                               // [19:10] result_value, [20] sequence_done, rest 0
	output logic [1:0]  m_tuser,   // [1:0] status
	// Configuration writes.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [39:0] cfg_wdata
);

	logic                valid_s1;
	logic [1:0]          req_s1;
	logic [5:0]          channel_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                valid_s2;
	result_t             result_s2;
	seq_state_t          state_q;
	cfg_t                cfg_q;
	seq_state_t          state_next;
	result_t             result_next;
	logic                advance;

	// The input register moves forward whenever the result register is free or
	// being emptied in this cycle.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1     <= s_tuser;
			channel_s1 <= s_tdata[5:0];
			sample_s1  <= s_tdata[15:6];
		end
	end

	acss_step u_step (
		.req_type   (req_s1),
		.channel    (channel_s1),
		.sample     (sample_s1),
		.cfg        (cfg_q),
		.state      (state_q),
		.state_next (state_next),
		.result     (result_next)
	);

	// The sequencer state changes only when an item's result is committed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_next;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_next;
		end
	end

	// Configuration registers; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.eight_bit <= 1'b1;
			cfg_q.scan_len  <= 4'd1;
			cfg_q.scan_list <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EIGHT_BIT: cfg_q.eight_bit <= cfg_wdata[0];
				CFG_SCAN_LEN:  cfg_q.scan_len  <= cfg_wdata[3:0];
				CFG_SCAN_LIST: cfg_q.scan_list <= cfg_wdata[LIST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = result_s2.status;
	assign m_tdata  = {3'b000, result_s2.done, result_s2.value, result_s2.idx,
		result_s2.valid, result_s2.mux, result_s2.start};

endmodule
